FILE: src/cfwd_pkg.sv
// Package with the shared types, sizes and helper functions of the circular FIFO.
`default_nettype none

package cfwd_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int DW    = 8;

    localparam logic [LW-1:0] LEN_MIN = LW'(2);
    localparam logic [LW-1:0] LEN_MAX = LW'(DEPTH);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_DUMP   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    do_insert;
        logic    do_pop;
        logic    dump_start;
        logic    dump_step;
        logic    do_clear;
        logic    load_out;
        t_status status;
        logic    data_sel;
        logic    last_from_cur;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic out_free;
        logic cur_is_tail;
    } t_dp_stat;

    // Advance a pointer by one slot, wrapping at the ring length.
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p, input logic [LW-1:0] len);
        logic [LW-1:0] n;
        n = LW'(p) + LW'(1);
        return (n >= len) ? '0 : n[AW-1:0];
    endfunction

    // Clamp a written ring length into the supported range.
    function automatic logic [LW-1:0] f_clamp(input logic [LW-1:0] v);
        logic [LW-1:0] r;
        r = v;
        if (v < LEN_MIN) r = LEN_MIN;
        else if (v > LEN_MAX) r = LEN_MAX;
        return r;
    endfunction

    // Number of bytes held between the head and tail pointers.
    function automatic logic [AW-1:0] f_count(input logic [AW-1:0] h, input logic [AW-1:0] t,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] c;
        if (h <= t) c = LW'(t) - LW'(h);
        else c = len - (LW'(h) - LW'(t));
        return c[AW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/cfwd_req_if.sv
// Request channel interface: valid, ready and the request payload.
`default_nettype none

interface cfwd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

`default_nettype wire

FILE: src/cfwd_res_if.sv
// Result channel interface: valid, ready and the result payload.
`default_nettype none

interface cfwd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_out;
    logic [5:0] item_count;
    logic       is_empty;
    logic       is_full;
    logic       last;

    modport source (output valid, output status, output data_out, output item_count,
                    output is_empty, output is_full, output last, input ready);
    modport sink   (input valid, input status, input data_out, input item_count,
                    input is_empty, input is_full, input last, output ready);
endinterface

`default_nettype wire

FILE: src/cfwd_dp.sv
// Datapath of the circular FIFO: pointers, slot memory, dump cursor and result register.
`default_nettype none

module cfwd_dp
    import cfwd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [LW-1:0] i_cfg_data,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [DW-1:0] i_data_in,
    input  wire t_cmd          i_cmd,
    input  wire logic          i_res_ready,
    output t_dp_stat           o_stat,
    output logic               o_res_valid,
    output logic [1:0]         o_status,
    output logic [DW-1:0]      o_data_out,
    output logic [AW-1:0]      o_item_count,
    output logic               o_is_empty,
    output logic               o_is_full,
    output logic               o_last
);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_len;
    logic [AW-1:0] r_cur;
    t_req          r_req;
    logic [DW-1:0] r_din;
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [DW-1:0] r_data_out;
    logic [AW-1:0] r_count;
    logic          r_empty;
    logic          r_full;
    logic          r_last;

    logic [AW-1:0] head_nx;
    logic [AW-1:0] tail_nx;
    logic [AW-1:0] cur_nx;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          out_free;

    assign head_nx  = f_next(r_head, r_len);
    assign tail_nx  = f_next(r_tail, r_len);
    assign cur_nx   = f_next(r_cur, r_len);
    assign rd_addr  = i_cmd.dump_step ? cur_nx : head_nx;
    assign rd_en    = i_cmd.do_pop | i_cmd.dump_start | i_cmd.dump_step;
    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cmd.do_clear) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_cmd.do_insert) n_tail = tail_nx;
            if (i_cmd.do_pop)    n_head = head_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_len  <= LEN_MAX;
        end else if (i_cfg_we) begin
            r_len  <= f_clamp(i_cfg_data);
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= t_req'(i_req_type);
            r_din <= i_data_in;
        end
        if (i_cmd.dump_start) r_cur <= head_nx;
        else if (i_cmd.dump_step) r_cur <= cur_nx;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) r_mem[tail_nx] <= r_din;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Flags and count follow the pointers as they stand after the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status   <= i_cmd.status;
            r_data_out <= i_cmd.data_sel ? r_rd_data : '0;
            r_count    <= f_count(n_head, n_tail, r_len);
            r_empty    <= (n_head == n_tail);
            r_full     <= (f_next(n_tail, r_len) == n_head);
            r_last     <= i_cmd.last_from_cur ? (r_cur == r_tail) : 1'b1;
        end
    end

    assign o_stat.req         = r_req;
    assign o_stat.full        = (tail_nx == r_head);
    assign o_stat.empty       = (r_head == r_tail);
    assign o_stat.out_free    = out_free;
    assign o_stat.cur_is_tail = (r_cur == r_tail);

    assign o_res_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_out   = r_data_out;
    assign o_item_count = r_count;
    assign o_is_empty   = r_empty;
    assign o_is_full    = r_full;
    assign o_last       = r_last;

endmodule

`default_nettype wire

FILE: src/cfwd_ctrl.sv
// Controller state machine of the circular FIFO: sequences each request over the datapath.
`default_nettype none

module cfwd_ctrl
    import cfwd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_req_ready,
    output t_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.status  = ST_OK;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.req)
                    REQ_INSERT: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out  = 1'b1;
                            o_cmd.status    = i_stat.full ? ST_FULL : ST_OK;
                            o_cmd.do_insert = !i_stat.full;
                            n_state         = S_IDLE;
                        end
                    end
                    REQ_POP, REQ_DUMP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.load_out = 1'b1;
                                o_cmd.status   = ST_EMPTY;
                                n_state        = S_IDLE;
                            end
                        end else begin
                            o_cmd.do_pop     = (i_stat.req == REQ_POP);
                            o_cmd.dump_start = (i_stat.req == REQ_DUMP);
                            n_state          = S_EMIT;
                        end
                    end
                    REQ_CLEAR: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            o_cmd.do_clear = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.data_sel = 1'b1;
                    if (i_stat.req == REQ_DUMP) begin
                        o_cmd.last_from_cur = 1'b1;
                        if (i_stat.cur_is_tail) n_state = S_IDLE;
                        else o_cmd.dump_step = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/circular_fifo_with_dump.sv
// Top level of the circular byte FIFO with insert, pop, dump and clear requests.
// Sequence: an insert, a clear or a refused request loads its result in the execute state
// once the output register is free; a pop loads it in the emit state, after the registered
// read of the slot memory. A dump of n held bytes loads one result a cycle in the emit state
// while the output register is free. One request at a time: the next item is accepted when
// the controller is idle again, after the last result of the previous one is loaded.
// Reset (synchronous, active low) empties the ring and sets the ring length to its maximum.
`default_nettype none

module circular_fifo_with_dump
    import cfwd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [LW-1:0] i_cfg_data,
    cfwd_req_if.sink           i_req,
    cfwd_res_if.source         o_res
);

    // The controller and the datapath talk only through these two structures.
    t_cmd     cmd;
    t_dp_stat stat;

    // Output payload from the datapath's result register.
    logic [AW-1:0] item_count;

    // The controller accepts an item only when it is idle. A finished result sits in the
    // datapath's output register, so a new item may be accepted while it waits to be taken;
    // the controller then holds back before overwriting that register.
    cfwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // The datapath keeps the head and tail pointers, the slot memory, the dump cursor and
    // the result register. A write of the ring length also clears both pointers, so held
    // bytes are dropped.
    cfwd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req.req_type),
        .i_data_in    (i_req.data_in),
        .i_cmd        (cmd),
        .i_res_ready  (o_res.ready),
        .o_stat       (stat),
        .o_res_valid  (o_res.valid),
        .o_status     (o_res.status),
        .o_data_out   (o_res.data_out),
        .o_item_count (item_count),
        .o_is_empty   (o_res.is_empty),
        .o_is_full    (o_res.is_full),
        .o_last       (o_res.last)
    );

    // The count field is six bits wide, which matches the pointer width at full depth.
    assign o_res.item_count = 6'(item_count);

endmodule

`default_nettype wire
